FILE: rtl/core/sorted_key_table_core_macros.svh
// Assertion macros for the sorted key table core.
// Used by the top level only; expects signals clk and rst in scope.
`ifndef SORTED_KEY_TABLE_CORE_MACROS_SVH
`define SORTED_KEY_TABLE_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SKT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define SKT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/skt_pkg.sv
// Shared types and constants for the sorted key table core.
// No dependencies.
`timescale 1ns / 1ps

package skt_pkg;

  localparam int KEY_W      = 50;
  localparam int DEPTH_DEF  = 64;
  localparam int STATUS_W   = 2;
  localparam int COUNT_W    = 7;

  // Request codes
  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_DELETE = 1'b1;

  // Status codes
  localparam logic [STATUS_W-1:0] STAT_DONE      = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 2'd2;

  // Broadcast command to every cell of the chain
  typedef struct packed {
    logic             ins;   // shift right from the insert point
    logic             del;   // shift left from the matching entry
    logic [KEY_W-1:0] key;   // key under compare
  } skt_cmd_t;

endpackage

FILE: rtl/core/skt_cell.sv
// One slot of the sorted key chain: holds a key, compares it to the
// broadcast key and takes a neighbor's key on insert or delete. Uses skt_pkg.
`timescale 1ns / 1ps

module skt_cell import skt_pkg::*; (
  input  logic             clk,
  input  skt_cmd_t         cmd,
  input  logic             occ,        // slot holds a live key
  input  logic [KEY_W-1:0] left_key,
  input  logic             left_gt,    // left slot is past the insert point
  input  logic             left_ge,    // left slot is at or past the delete point
  input  logic [KEY_W-1:0] right_key,
  output logic [KEY_W-1:0] key,
  output logic             gt,
  output logic             ge,
  output logic             hit
);

  logic [KEY_W-1:0] key_next;

  // Empty slots count as "greater" so an insert lands at the tail.
  assign gt  = !occ || (key > cmd.key);
  assign ge  = occ && (key >= cmd.key);
  // First slot at or above the key, and equal to it.
  assign hit = ge && !left_ge && (key == cmd.key);

  always_comb begin
    key_next = key;
    priority if (cmd.ins && gt && !left_gt) begin
      key_next = cmd.key;
    end else if (cmd.ins && gt) begin
      key_next = left_key;
    end else if (cmd.del && ge) begin
      key_next = right_key;
    end
  end

  always_ff @(posedge clk) begin
    key <= key_next;
  end

endmodule

FILE: rtl/core/sorted_key_table_core.sv
// Sorted key table top level: command port, control sequencer and the
// chain of skt_cell slots. Uses skt_pkg and sorted_key_table_core_macros.svh.
`timescale 1ns / 1ps
`include "sorted_key_table_core_macros.svh"

//  channel  | handshake          | payload
//  ---------+--------------------+-------------------------------------------
//  request  | start / busy       | req_type, key
//  result   | done (one cycle)   | status, entry_count, min_key, max_key, nonempty
//
// One beat in passes through the latch, chain update and result capture steps. The
// result is registered with done from the capture step, and a new start is
// taken while done is high; no new item is taken before the last one is done.
// The chain update is a single parallel shift across all slots; the result
// stage reads the tail slot through a one-hot AND-OR over the chain.
// rst clears the sequencer and the count; slot keys are left as they are.
// The receiver cannot stall: done is a one-cycle strobe.

module sorted_key_table_core import skt_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic                req_type,
  input  logic [KEY_W-1:0]    key,
  output logic                done,
  output logic [STATUS_W-1:0] status,
  output logic [COUNT_W-1:0]  entry_count,
  output logic [KEY_W-1:0]    min_key,
  output logic [KEY_W-1:0]    max_key,
  output logic                nonempty
);

  localparam int CW = $clog2(DEPTH + 1);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_EXEC   = 2'd1;
  localparam logic [1:0] ST_REPORT = 2'd2;

  logic [1:0]          state;
  logic [1:0]          state_next;

  // latched request
  logic                req_op;
  logic [KEY_W-1:0]    req_key;

  logic [CW-1:0]       count;
  logic [STATUS_W-1:0] exec_status;

  // chain wiring; index 0 of the flag vectors is the left edge
  skt_cmd_t            cmd;
  logic [KEY_W-1:0]    cell_key [DEPTH];
  logic [DEPTH:0]      gt_vec;
  logic [DEPTH:0]      ge_vec;
  logic [DEPTH-1:0]    hit_vec;
  logic [DEPTH:0]      occ;

  logic                full;
  logic                found;
  logic                accept;
  logic [KEY_W-1:0]    tail_key;
  logic [CW+COUNT_W-1:0] count_ext;

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;
  assign full   = (count == CW'(DEPTH));
  assign found  = |hit_vec;

  assign cmd.key = req_key;
  assign cmd.ins = (state == ST_EXEC) && (req_op == REQ_INSERT) && !full;
  assign cmd.del = (state == ST_EXEC) && (req_op == REQ_DELETE) && found;

  assign gt_vec[0]  = 1'b0;
  assign ge_vec[0]  = 1'b0;
  assign occ[DEPTH] = 1'b0;

  // ---------------------------------------------------------------------
  // Slot chain
  // ---------------------------------------------------------------------
  for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
    logic [KEY_W-1:0] lkey;
    logic [KEY_W-1:0] rkey;

    assign occ[gi] = (count > CW'(gi));

    if (gi == 0) begin : g_left_edge
      assign lkey = req_key;   // never taken: left_gt is low here
    end else begin : g_left
      assign lkey = cell_key[gi-1];
    end

    if (gi == DEPTH - 1) begin : g_right_edge
      assign rkey = cell_key[gi]; // slot drops out of the count on delete
    end else begin : g_right
      assign rkey = cell_key[gi+1];
    end

    skt_cell u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .occ       (occ[gi]),
      .left_key  (lkey),
      .left_gt   (gt_vec[gi]),
      .left_ge   (ge_vec[gi]),
      .right_key (rkey),
      .key       (cell_key[gi]),
      .gt        (gt_vec[gi+1]),
      .ge        (ge_vec[gi+1]),
      .hit       (hit_vec[gi])
    );
  end

  // Tail slot: the one live slot whose right neighbor is empty.
  always_comb begin
    tail_key = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (occ[i] && !occ[i+1]) begin
        tail_key = tail_key | cell_key[i];
      end
    end
  end

  assign count_ext = {{COUNT_W{1'b0}}, count};

  // ---------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (start) state_next = ST_EXEC;
      ST_EXEC:   state_next = ST_REPORT;
      ST_REPORT: state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == ST_REPORT);
      if (cmd.ins) begin
        count <= count + CW'(1);
      end else if (cmd.del) begin
        count <= count - CW'(1);
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      req_op  <= req_type;
      req_key <= key;
    end
    if (state == ST_EXEC) begin
      if (req_op == REQ_INSERT) begin
        exec_status <= full ? STAT_FULL : STAT_DONE;
      end else begin
        exec_status <= found ? STAT_DONE : STAT_NOT_FOUND;
      end
    end
    if (state == ST_REPORT) begin
      status      <= exec_status;
      entry_count <= count_ext[COUNT_W-1:0];
      nonempty    <= occ[0];
      min_key     <= occ[0] ? cell_key[0] : '0;
      max_key     <= tail_key;
    end
  end

  // ---------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------
  `SKT_ASSERT_NXT(a_accept_exec, accept, state == ST_EXEC, "accepted beat did not start")
  `SKT_ASSERT_IMP(a_done_idle, done, state == ST_IDLE, "result strobe while busy")
  `SKT_ASSERT_IMP(a_count_range, 1'b1, count <= CW'(DEPTH), "count above depth")
  `SKT_ASSERT_IMP(a_done_nonempty, done, nonempty == (count != '0), "nonempty flag off")
  `SKT_ASSERT_IMP(a_full_status, done && (status == STAT_FULL), count == CW'(DEPTH),
                  "full status with room left")

endmodule
